// ===== sv/dmd_pkg.sv =====
// ----------------------------------------------------------------------------
// dmd_pkg
// Shared types and constants for the device message deframer and buffer.
// ----------------------------------------------------------------------------
package dmd_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int MAX_BYTES   = 8;
   localparam int BYTES_W     = 8 * MAX_BYTES;
   localparam int COUNT_W     = 4;

   localparam logic [7:0] HDR_LEN_MASK  = 8'h70;
   localparam int         HDR_LEN_SHIFT = 4;
   localparam int         HDR_DEV_BIT   = 7;

   typedef enum logic {
      OP_BYTE,
      OP_READ
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_COMMIT
   } back_state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] rx_byte;
      logic       want_device;
   } qitem_type;

   typedef struct packed {
      logic               device;
      logic [COUNT_W-1:0] count;
      logic [BYTES_W-1:0] bytes;
   } entry_type;

   typedef struct packed {
      logic      append;
      entry_type msg;
      logic      search;
      logic      want;
      logic      commit;
   } store_ctrl_type;

   typedef struct packed {
      logic              hit;
      entry_type         entry;
      logic              overflow;
      logic [FILL_W-1:0] fill;
   } store_stat_type;

endpackage

// ===== sv/device_message_deframer_buffer_core.sv =====
// ----------------------------------------------------------------------------
// device_message_deframer_buffer_core
// Deframes device messages from serial bytes into an ordered store and
// serves per-device read requests, oldest message first.
// ----------------------------------------------------------------------------
// Timing: a byte word is applied at the edge that pops it from the input
//   queue; a read word matches on that edge and is removed in BK_COMMIT,
//   which waits while the response register is held; its response is
//   registered at the edge that removes it.
// Throughput: one byte word per cycle while the sequencer is idle; a read
//   word holds off later words until its match-then-compact pass is done.
// Reset: synchronous, active high; queue, assembler, store fill count,
//   overflow flag and response valid are cleared. No clearing pass.
// ----------------------------------------------------------------------------
module device_message_deframer_buffer_core
   import dmd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_want_device,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic                rsp_source_device,
   output logic [COUNT_W-1:0]  rsp_byte_count,
   output logic [BYTES_W-1:0]  rsp_message_bytes,
   output logic                rsp_overflow_seen
);

   // front: accept and queue words
   logic      head_valid;
   qitem_type head;
   logic      pop;

   dmd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_rx_byte     (req_rx_byte),
      .req_want_device (req_want_device),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop)
   );

   // back: assembler + store, driven by a small sequencer
   logic           take;
   logic           asm_done;
   entry_type      asm_msg;
   store_ctrl_type ctrl;
   store_stat_type stat;

   dmd_assembler u_asm (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (head.rx_byte),
      .done    (asm_done),
      .msg     (asm_msg)
   );

   dmd_store u_store (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat)
   );

   back_state_type     state_ff, state_in;
   logic               load;

   logic               rsp_valid_ff;
   logic               found_ff;
   logic               dev_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic               ovf_ff;

   always_comb begin
      state_in    = state_ff;
      pop         = 1'b0;
      take        = 1'b0;
      load        = 1'b0;
      ctrl        = '0;
      ctrl.append = asm_done;
      ctrl.msg    = asm_msg;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head.op == OP_READ) begin
                  // snapshot per-cell matches; store is stable until commit
                  ctrl.search = 1'b1;
                  ctrl.want   = head.want_device;
                  state_in    = BK_COMMIT;
               end else begin
                  take = 1'b1;
               end
            end
         end
         BK_COMMIT: begin
            // response register free (or draining): remove and report
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.commit = 1'b1;
               load        = 1'b1;
               state_in    = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload; the store hands back all zeros on a miss
   always_ff @(posedge clock) begin
      if (load) begin
         found_ff <= stat.hit;
         dev_ff   <= stat.entry.device;
         count_ff <= stat.entry.count;
         bytes_ff <= stat.entry.bytes;
         ovf_ff   <= stat.overflow;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_source_device = dev_ff;
   assign rsp_byte_count    = count_ff;
   assign rsp_message_bytes = bytes_ff;
   assign rsp_overflow_seen = ovf_ff;

   // a new response only ever follows a commit cycle
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == BK_COMMIT))
      else $error("response raised without a commit");

   // a miss reports an empty message
   a_miss_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !found_ff) |-> (count_ff == '0 && bytes_ff == '0 && !dev_ff))
      else $error("miss response carries message data");

   // fill count stays within the store
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      stat.fill <= FILL_W'(STORE_DEPTH))
      else $error("store fill count out of range");

   // overflow is sticky
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      stat.overflow |=> stat.overflow)
      else $error("overflow flag cleared");

endmodule

// ===== sv/dmd_front.sv =====
// ----------------------------------------------------------------------------
// dmd_front
// Accepts request words, tags them as byte or read, and queues them.
// ----------------------------------------------------------------------------
module dmd_front
   import dmd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic      req_cmd,
   input  logic [7:0] req_rx_byte,
   input  logic      req_want_device,
   output logic      head_valid,
   output qitem_type head,
   input  logic      pop
);

   qitem_type          q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  cnt_ff;
   logic               push;
   qitem_type          item;

   assign req_ready  = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      item.op          = req_cmd ? OP_READ : OP_BYTE;
      item.rx_byte     = req_rx_byte;
      item.want_device = req_want_device;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== sv/dmd_assembler.sv =====
// ----------------------------------------------------------------------------
// dmd_assembler
// Gathers serial bytes into one message, header first.
// ----------------------------------------------------------------------------
module dmd_assembler
   import dmd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] rx_byte,
   output logic       done,
   output entry_type  msg
);

   logic               dev_ff, dev_in;
   logic [3:0]         rem_ff, rem_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   logic               dev;
   logic [3:0]         rem;
   logic [BYTES_W-1:0] bytes;
   logic [COUNT_W-1:0] cnt;

   always_comb begin
      dev   = dev_ff;
      rem   = rem_ff;
      bytes = bytes_ff;
      cnt   = cnt_ff;
      // no message open: this byte is a header
      if (rem_ff == '0) begin
         dev   = rx_byte[HDR_DEV_BIT];
         rem   = 4'(1 + ((rx_byte & HDR_LEN_MASK) >> HDR_LEN_SHIFT));
         bytes = '0;
         cnt   = '0;
      end
      if (!cnt[3]) begin
         bytes = bytes | (BYTES_W'(rx_byte) << {cnt[2:0], 3'b000});
      end
      cnt = cnt + 1'b1;
      rem = rem - 1'b1;

      done       = take && (rem == '0);
      msg.device = dev;
      msg.count  = cnt;
      msg.bytes  = bytes;

      dev_in   = dev_ff;
      rem_in   = rem_ff;
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      if (take) begin
         if (rem == '0) begin
            dev_in   = 1'b0;
            rem_in   = '0;
            bytes_in = '0;
            cnt_in   = '0;
         end else begin
            dev_in   = dev;
            rem_in   = rem;
            bytes_in = bytes;
            cnt_in   = cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff   <= 1'b0;
         rem_ff   <= '0;
         bytes_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         dev_ff   <= dev_in;
         rem_ff   <= rem_in;
         bytes_ff <= bytes_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== sv/dmd_store.sv =====
// ----------------------------------------------------------------------------
// dmd_store
// Ordered message store as a row of cells: append, match, remove-and-compact.
// ----------------------------------------------------------------------------
module dmd_store
   import dmd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  store_ctrl_type ctrl,
   output store_stat_type stat
);

   entry_type              cell_ff [STORE_DEPTH];
   logic [FILL_W-1:0]      fill_ff;
   logic [STORE_DEPTH-1:0] match_ff;
   logic                   ovf_ff;

   logic                   full;
   logic [STORE_DEPTH-1:0] pre;
   logic [STORE_DEPTH-1:0] first;
   entry_type              sel;

   assign full = (fill_ff == FILL_W'(STORE_DEPTH));

   // inclusive prefix-or of matches, log steps; pre[i] set = cell i shifts down
   always_comb begin
      pre = match_ff;
      for (int s = 0; s < IDX_W; s++) begin
         pre = pre | (pre << (1 << s));
      end
      first = match_ff & ~(pre << 1);
      sel   = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (first[i]) begin
            sel = sel | cell_ff[i];
         end
      end
      stat.hit      = |match_ff;
      stat.entry    = sel;
      stat.overflow = ovf_ff;
      stat.fill     = fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         if (ctrl.append) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               fill_ff <= fill_ff + 1'b1;
            end
         end else if (ctrl.commit && stat.hit) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.append && !full) begin
         cell_ff[fill_ff[IDX_W-1:0]] <= ctrl.msg;
      end
      if (ctrl.commit && stat.hit) begin
         for (int i = 0; i < STORE_DEPTH - 1; i++) begin
            if (pre[i]) begin
               cell_ff[i] <= cell_ff[i + 1];
            end
         end
      end
      if (ctrl.search) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            match_ff[i] <= (FILL_W'(i) < fill_ff) && (cell_ff[i].device == ctrl.want);
         end
      end
   end

endmodule

// ===== tb/device_message_deframer_buffer_core_tb.sv =====
// ----------------------------------------------------------------------------
// device_message_deframer_buffer_core_tb
// Self-checking bench for the message deframer and per-device message store.
// Byte and read words are sent with random gaps. The bench frames the bytes
// itself, keeps its own copy of the store, and checks each read reply field
// by field. It runs a directed pass first, then random traffic under three
// idle profiles, and ends by filling the store until it overflows.
// ----------------------------------------------------------------------------
module device_message_deframer_buffer_core_tb;
   import dmd_pkg::*;

   // expected reply to one read word
   typedef struct packed {
      logic               found;
      logic               device;
      logic [COUNT_W-1:0] count;
      logic [BYTES_W-1:0] bytes;
      logic               overflow;
   } read_reply_type;

   localparam int unsigned STALL_LIMIT = 4000;  // cycles with no word moving
   localparam int unsigned DRAIN_WAIT  = 20;    // settle time after last reply

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_cmd = 1'b0;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                req_want_device = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_found;
   logic                rsp_source_device;
   logic [COUNT_W-1:0]  rsp_byte_count;
   logic [BYTES_W-1:0]  rsp_message_bytes;
   logic                rsp_overflow_seen;

   device_message_deframer_buffer_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_rx_byte       (req_rx_byte),
      .req_want_device   (req_want_device),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_source_device (rsp_source_device),
      .rsp_byte_count    (rsp_byte_count),
      .rsp_message_bytes (rsp_message_bytes),
      .rsp_overflow_seen (rsp_overflow_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Framing and store predictor
   // --------------------------------------------------------------------------
   int unsigned        frame_left  = 0;   // 0: next byte is a header
   logic               frame_dev   = 1'b0;
   logic [BYTES_W-1:0] frame_bytes = '0;
   int unsigned        frame_count = 0;
   logic               store_overflowed = 1'b0;
   entry_type          stored_msgs[$];    // oldest first
   read_reply_type     due_replies[$];    // replies owed by the block, in order

   int unsigned words_sent = 0;
   int unsigned bytes_sent = 0;
   int unsigned read_hits  = 0;
   int unsigned read_misses = 0;
   int unsigned fail_count = 0;

   // one received byte; a header opens a frame, the last byte stores it
   function automatic void absorb_byte(logic [7:0] b);
      entry_type e;
      if (frame_left == 0) begin
         frame_dev   = b[HDR_DEV_BIT];
         frame_left  = 1 + ((b & HDR_LEN_MASK) >> HDR_LEN_SHIFT);
         frame_bytes = '0;
         frame_count = 0;
      end
      frame_bytes[8*frame_count +: 8] = b;
      frame_count++;
      frame_left--;
      if (frame_left == 0) begin
         if (stored_msgs.size() < STORE_DEPTH) begin
            e.device    = frame_dev;
            e.count     = COUNT_W'(frame_count);
            e.bytes     = frame_bytes;
            stored_msgs = {stored_msgs, e};
         end else begin
            store_overflowed = 1'b1;   // full store: frame dropped, flag sticks
         end
      end
   endfunction

   // read word: pull the oldest frame of the device, keep order of the rest
   function automatic read_reply_type take_oldest(logic dev);
      read_reply_type r;
      int             i;
      r          = '0;
      r.overflow = store_overflowed;
      for (i = 0; i < stored_msgs.size(); i++) begin
         if (stored_msgs[i].device == dev) begin
            r.found  = 1'b1;
            r.device = stored_msgs[i].device;
            r.count  = stored_msgs[i].count;
            r.bytes  = stored_msgs[i].bytes;
            stored_msgs.delete(i);
            break;
         end
      end
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Word sender
   // --------------------------------------------------------------------------
   int unsigned feed_gap_pct   = 0;   // chance of an idle cycle before a word
   int unsigned sink_stall_pct = 0;   // chance rsp_ready is low in a cycle

   // valid is only lowered in idle cycles, so back-to-back words keep it high
   task automatic send_word(input op_type op, input logic [7:0] data,
                            input logic dev);
      read_reply_type r;
      while ($urandom_range(99) < feed_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= op;
      req_rx_byte     <= data;
      req_want_device <= dev;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (op == OP_BYTE) begin
         bytes_sent++;
         absorb_byte(data);
      end else begin
         r = take_oldest(dev);
         if (r.found) read_hits++;
         else read_misses++;
         due_replies = {due_replies, r};
      end
   endtask

   // unused fields of a word carry random junk
   task automatic send_byte(input logic [7:0] data);
      send_word(OP_BYTE, data, 1'($urandom_range(1)));
   endtask

   task automatic send_read(input logic dev);
      send_word(OP_READ, 8'($urandom), dev);
   endtask

   // header plus its payload; reads may be slipped in between payload bytes
   task automatic send_message(input logic [7:0] header,
                               input int unsigned interleave_pct);
      int unsigned k;
      send_byte(header);
      for (k = 0; k < ((header & HDR_LEN_MASK) >> HDR_LEN_SHIFT); k++) begin
         if ($urandom_range(99) < interleave_pct)
            send_read(1'($urandom_range(1)));
         send_byte(8'($urandom));
      end
   endtask

   // --------------------------------------------------------------------------
   // Reply checker and rsp_ready pattern
   // --------------------------------------------------------------------------
   read_reply_type got_exp;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_replies.size() == 0) begin
               $error("reply word with no read outstanding");
               fail_count++;
            end else begin
               got_exp = due_replies.pop_front();
               if (rsp_found !== got_exp.found) begin
                  $error("found: expected %0d, got %0d", got_exp.found, rsp_found);
                  fail_count++;
               end
               if (rsp_source_device !== got_exp.device) begin
                  $error("source_device: expected %0d, got %0d",
                         got_exp.device, rsp_source_device);
                  fail_count++;
               end
               if (rsp_byte_count !== got_exp.count) begin
                  $error("byte_count: expected %0d, got %0d",
                         got_exp.count, rsp_byte_count);
                  fail_count++;
               end
               if (rsp_message_bytes !== got_exp.bytes) begin
                  $error("message_bytes: expected %h, got %h",
                         got_exp.bytes, rsp_message_bytes);
                  fail_count++;
               end
               if (rsp_overflow_seen !== got_exp.overflow) begin
                  $error("overflow_seen: expected %0d, got %0d",
                         got_exp.overflow, rsp_overflow_seen);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // watchdog: any word moving on either side restarts the count
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // empty store, field extremes, out-of-order device pickup, misses
   task automatic test_directed();
      send_read(1'b0);                 // empty store, both devices miss
      send_read(1'b1);
      send_byte(8'h00);                // dev 0, header only
      send_byte(8'hFF);                // dev 1, full 8-byte frame
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
      send_byte(8'hA5);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'h7E);
      send_byte(8'h80);                // dev 1, header only
      send_byte(8'h10);                // dev 0, two bytes
      send_byte(8'hC3);
      send_read(1'b1);                 // skips older dev 0 frame
      send_read(1'b0);
      send_read(1'b0);
      send_read(1'b1);
      send_read(1'b1);                 // dev 1 drained
      send_read(1'b0);                 // dev 0 drained
   endtask

   // mostly whole frames and reads, some frames broken up by reads
   task automatic test_random_traffic(input int unsigned words,
                                      input int unsigned gap_pct,
                                      input int unsigned stall_pct);
      int unsigned start;
      int unsigned pick;
      feed_gap_pct   = gap_pct;
      sink_stall_pct = stall_pct;
      start          = words_sent;
      while (words_sent - start < words) begin
         pick = $urandom_range(99);
         if (pick < 45)
            send_message(8'($urandom), 0);
         else if (pick < 88)
            send_read(1'($urandom_range(1)));
         else
            send_message(8'($urandom), 50);
      end
   endtask

   // fill past capacity so frames drop and the sticky flag shows, then drain
   task automatic test_store_full();
      int unsigned n;
      for (n = 0; n < STORE_DEPTH + 4; n++)
         send_message({1'($urandom_range(1)), 3'($urandom_range(2)), 4'($urandom)}, 0);
      for (n = 0; n < 2 * STORE_DEPTH + 8; n++)
         send_read(1'($urandom_range(1)));
      // more traffic with the flag already set
      test_random_traffic(150, 16, 49);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(385, 16, 49);
      test_random_traffic(385, 49, 16);
      test_random_traffic(385, 0, 0);
      test_store_full();

      req_valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d words: %0d bytes, %0d reads (%0d hits, %0d misses)",
               words_sent, bytes_sent, read_hits + read_misses, read_hits, read_misses);
      $display("store overflow reached: %0d, frames left in store: %0d",
               store_overflowed, stored_msgs.size());
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
